// ===== sv/sec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_pkg
// Shared types and constants for the sonar echo swipe classifier.
// ----------------------------------------------------------------------------
package sec_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_BITS       = 16;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int FLAG_BITS      = 6;
    localparam int OUT_DATA_BITS  = ((FLAG_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_SWIPE_MIN  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SWIPE_FAST = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SWIPE_MAX  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_X_RANGE    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DROP_MIN   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DROP_MAX   = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_Y_RANGE    = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ROTATE_MIN = 3'd7;

    // thresholds in timer ticks (cm * 58)
    localparam logic [CFG_BITS-1:0] SWIPE_MIN_RST  = 16'd87;
    localparam logic [CFG_BITS-1:0] SWIPE_FAST_RST = 16'd870;
    localparam logic [CFG_BITS-1:0] SWIPE_MAX_RST  = 16'd3480;
    localparam logic [CFG_BITS-1:0] X_RANGE_RST    = 16'd4640;
    localparam logic [CFG_BITS-1:0] DROP_MIN_RST   = 16'd290;
    localparam logic [CFG_BITS-1:0] DROP_MAX_RST   = 16'd2900;
    localparam logic [CFG_BITS-1:0] Y_RANGE_RST    = 16'd5800;
    localparam logic [CFG_BITS-1:0] ROTATE_MIN_RST = 16'd2900;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] rotate_min;
        logic [CFG_BITS-1:0] y_range;
        logic [CFG_BITS-1:0] drop_max;
        logic [CFG_BITS-1:0] drop_min;
        logic [CFG_BITS-1:0] x_range;
        logic [CFG_BITS-1:0] swipe_max;
        logic [CFG_BITS-1:0] swipe_fast;
        logic [CFG_BITS-1:0] swipe_min;
    } sec_cfg_t;

    // packed from the lowest bit up: right_slow .. rotate
    typedef struct packed {
        logic rotate;
        logic drop;
        logic left_fast;
        logic left_slow;
        logic right_fast;
        logic right_slow;
    } sec_flags_t;

endpackage

// ===== sv/sec_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_axis
// Per-channel echo pairing: holds the first edge, derives the pulse width
// and keeps a two-deep width history.
// ----------------------------------------------------------------------------
module sec_axis #(
    parameter int COUNT_BITS = sec_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  capture_en,
    input  logic [COUNT_BITS-1:0] capture_count,
    output logic                  pending,
    output logic [COUNT_BITS-1:0] width,
    output logic [COUNT_BITS-1:0] newest,
    output logic [COUNT_BITS-1:0] previous
);

    logic                  pending_reg;
    logic [COUNT_BITS-1:0] first_reg;
    logic [COUNT_BITS-1:0] width_reg;
    logic [COUNT_BITS-1:0] newest_reg;
    logic [COUNT_BITS-1:0] previous_reg;
    logic [COUNT_BITS-1:0] width_next;
    logic [COUNT_BITS-1:0] diff;

    assign diff = capture_count - first_reg;

    // on wrap the width is one tick short of the modular difference
    always_comb
    begin
        if (capture_count > first_reg)
        begin
            width_next = diff;
        end
        else if (capture_count < first_reg)
        begin
            width_next = diff - {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            width_next = width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            first_reg    <= '0;
            width_reg    <= '0;
            newest_reg   <= '0;
            previous_reg <= '0;
        end
        else if (capture_en)
        begin
            if (!pending_reg)
            begin
                first_reg   <= capture_count;
                pending_reg <= 1'b1;
            end
            else
            begin
                width_reg    <= width_next;
                newest_reg   <= width_next;
                previous_reg <= newest_reg;
                pending_reg  <= 1'b0;
            end
        end
    end

    assign pending  = pending_reg;
    assign width    = width_reg;
    assign newest   = newest_reg;
    assign previous = previous_reg;

endmodule

// ===== sv/sec_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_classify
// Gesture decode: compares the width histories of both channels against
// the tick thresholds.
// ----------------------------------------------------------------------------
module sec_classify #(
    parameter int COUNT_BITS = sec_pkg::COUNT_BITS_DEF
) (
    input  sec_pkg::sec_cfg_t     cfg,
    input  logic [COUNT_BITS-1:0] x_newest,
    input  logic [COUNT_BITS-1:0] x_previous,
    input  logic [COUNT_BITS-1:0] y_newest,
    input  logic [COUNT_BITS-1:0] y_previous,
    input  logic                  y_live,
    output sec_pkg::sec_flags_t   flags
);

    localparam int CMP_W = (COUNT_BITS > sec_pkg::CFG_BITS) ? COUNT_BITS : sec_pkg::CFG_BITS;

    logic [CMP_W-1:0] xn, xp, yn, yp;
    logic [CMP_W-1:0] swipe_min, swipe_fast, swipe_max, x_range;
    logic [CMP_W-1:0] drop_min, drop_max, y_range, rotate_min;
    logic [CMP_W-1:0] x_fall, x_rise, y_fall, y_rise;
    logic             x_in_range, y_in_range;
    logic             x_slow_fall, x_fast_fall, x_slow_rise, x_fast_rise;

    assign xn = CMP_W'(x_newest);
    assign xp = CMP_W'(x_previous);
    assign yn = CMP_W'(y_newest);
    assign yp = CMP_W'(y_previous);

    assign swipe_min  = CMP_W'(cfg.swipe_min);
    assign swipe_fast = CMP_W'(cfg.swipe_fast);
    assign swipe_max  = CMP_W'(cfg.swipe_max);
    assign x_range    = CMP_W'(cfg.x_range);
    assign drop_min   = CMP_W'(cfg.drop_min);
    assign drop_max   = CMP_W'(cfg.drop_max);
    assign y_range    = CMP_W'(cfg.y_range);
    assign rotate_min = CMP_W'(cfg.rotate_min);

    assign x_fall = xp - xn;
    assign x_rise = xn - xp;
    assign y_fall = yp - yn;
    assign y_rise = yn - yp;

    assign x_in_range = (xn < x_range) && (xp < x_range);
    assign y_in_range = (yn < y_range) && (yp < y_range);

    assign x_slow_fall = (x_fall > swipe_min) && (x_fall < swipe_fast);
    assign x_fast_fall = (x_fall >= swipe_fast) && (x_fall < swipe_max);
    assign x_slow_rise = (x_rise > swipe_min) && (x_rise < swipe_fast);
    assign x_fast_rise = (x_rise >= swipe_fast) && (x_rise < swipe_max);

    always_comb
    begin
        flags            = '0;
        flags.right_slow = (xn < xp) && x_in_range && x_slow_fall;
        flags.right_fast = (xn < xp) && x_in_range && x_fast_fall;
        flags.left_slow  = (xn > xp) && x_in_range && x_slow_rise;
        flags.left_fast  = (xn > xp) && x_in_range && x_fast_rise;
        flags.drop       = (yn < yp) && y_in_range && y_live
                           && (y_fall > drop_min) && (y_fall < drop_max);
        flags.rotate     = (yn > yp) && y_live && (yp != '0) && (y_rise > rotate_min);
    end

endmodule

// ===== sv/sec_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_skid
// Output register with one skid entry, so the upstream stage keeps moving
// while a result waits on the master side.
// ----------------------------------------------------------------------------
module sec_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sec_pkg::sec_flags_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sec_pkg::sec_flags_t out_data
);

    logic                main_valid_reg;
    logic                skid_valid_reg;
    sec_pkg::sec_flags_t main_reg;
    sec_pkg::sec_flags_t skid_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !main_valid_reg)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_reg <= in_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== sv/sonar_echo_swipe_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_echo_swipe_classifier
// Flags of an accepted word reach the master side through the
//   capture/history stage, then the output register.
// Throughput: one capture word per cycle while m_tready holds; a skid entry absorbs one stall.
// Reset: rst_n clears both channels, the histories and the output stage;
//   the threshold registers load their tick defaults.
// ----------------------------------------------------------------------------
module sonar_echo_swipe_classifier #(
    parameter int COUNT_BITS = sec_pkg::COUNT_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((COUNT_BITS + 7) / 8) * 8 - 1:0]  s_tdata,  // capture_count
    input  logic                                     s_tuser,  // axis
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // right_slow, right_fast, left_slow, left_fast, drop, rotate, zero pad
    output logic [sec_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    input  logic                                     cfg_we,
    input  logic [sec_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
    input  logic [sec_pkg::CFG_BITS-1:0]             cfg_data
);

    sec_pkg::sec_cfg_t    cfg_reg;
    sec_pkg::sec_flags_t  flags;
    sec_pkg::sec_flags_t  out_flags;

    logic                  accept;
    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    logic                  skid_ready;
    logic                  y_measured_reg;
    logic                  y_pending;
    logic [COUNT_BITS-1:0] capture;
    logic [COUNT_BITS-1:0] x_newest, x_previous;
    logic [COUNT_BITS-1:0] y_newest, y_previous, y_width;

    assign capture  = s_tdata[COUNT_BITS-1:0];
    assign s_tready = !stage_valid_reg || skid_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (skid_ready)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            y_measured_reg  <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept && (s_tuser == sec_pkg::AXIS_Y) && y_pending)
            begin
                y_measured_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swipe_min  <= sec_pkg::SWIPE_MIN_RST;
            cfg_reg.swipe_fast <= sec_pkg::SWIPE_FAST_RST;
            cfg_reg.swipe_max  <= sec_pkg::SWIPE_MAX_RST;
            cfg_reg.x_range    <= sec_pkg::X_RANGE_RST;
            cfg_reg.drop_min   <= sec_pkg::DROP_MIN_RST;
            cfg_reg.drop_max   <= sec_pkg::DROP_MAX_RST;
            cfg_reg.y_range    <= sec_pkg::Y_RANGE_RST;
            cfg_reg.rotate_min <= sec_pkg::ROTATE_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sec_pkg::REG_SWIPE_MIN:  cfg_reg.swipe_min  <= cfg_data;
                sec_pkg::REG_SWIPE_FAST: cfg_reg.swipe_fast <= cfg_data;
                sec_pkg::REG_SWIPE_MAX:  cfg_reg.swipe_max  <= cfg_data;
                sec_pkg::REG_X_RANGE:    cfg_reg.x_range    <= cfg_data;
                sec_pkg::REG_DROP_MIN:   cfg_reg.drop_min   <= cfg_data;
                sec_pkg::REG_DROP_MAX:   cfg_reg.drop_max   <= cfg_data;
                sec_pkg::REG_Y_RANGE:    cfg_reg.y_range    <= cfg_data;
                sec_pkg::REG_ROTATE_MIN: cfg_reg.rotate_min <= cfg_data;
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    sec_axis #(
        .COUNT_BITS (COUNT_BITS)
    ) u_axis_x (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture_en    (accept && (s_tuser == sec_pkg::AXIS_X)),
        .capture_count (capture),
        .pending       (),
        .width         (),
        .newest        (x_newest),
        .previous      (x_previous)
    );

    sec_axis #(
        .COUNT_BITS (COUNT_BITS)
    ) u_axis_y (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture_en    (accept && (s_tuser == sec_pkg::AXIS_Y)),
        .capture_count (capture),
        .pending       (y_pending),
        .width         (y_width),
        .newest        (y_newest),
        .previous      (y_previous)
    );

    sec_classify #(
        .COUNT_BITS (COUNT_BITS)
    ) u_classify (
        .cfg        (cfg_reg),
        .x_newest   (x_newest),
        .x_previous (x_previous),
        .y_newest   (y_newest),
        .y_previous (y_previous),
        .y_live     (y_measured_reg && (y_width != '0)),
        .flags      (flags)
    );

    sec_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid_reg),
        .in_ready  (skid_ready),
        .in_data   (flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_flags)
    );

    assign m_tdata = sec_pkg::OUT_DATA_BITS'(out_flags);

endmodule

// ===== dv/swipe_flag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_flag_checker
// Watches the capture, config and flag channels of the swipe classifier,
// works out the six gesture flags for every capture word taken in and
// compares them, in order, with the flag words that come out.
// ----------------------------------------------------------------------------
module swipe_flag_checker #(
    parameter int COUNT_BITS = sec_pkg::COUNT_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    input  logic                                     s_tready,
    input  logic [((COUNT_BITS + 7) / 8) * 8 - 1:0]  s_tdata,  // capture_count
    input  logic                                     s_tuser,  // axis
    input  logic                                     m_tvalid,
    input  logic                                     m_tready,
    // right_slow, right_fast, left_slow, left_fast, drop, rotate, zero pad
    input  logic [sec_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    input  logic                                     cfg_we,
    input  logic [sec_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
    input  logic [sec_pkg::CFG_BITS-1:0]             cfg_data,
    output int                                       mismatches,
    output int                                       pending_results
);

    typedef struct packed {
        logic                  pending;
        logic [COUNT_BITS-1:0] first_edge;
        logic [COUNT_BITS-1:0] width;
        logic [COUNT_BITS-1:0] newest;
        logic [COUNT_BITS-1:0] previous;
    } echo_chan_t;

    echo_chan_t          x_chan;
    echo_chan_t          y_chan;
    logic                y_seen;
    sec_pkg::sec_cfg_t   thresholds;
    sec_pkg::sec_flags_t flags_due[$];

    initial
    begin
        mismatches      = 0;
        pending_results = 0;
    end

    // first edge of a pair is held; the second gives the width (old width on
    // equal captures) and shifts it into the two-deep history
    function automatic echo_chan_t echo_edge(echo_chan_t c, logic [COUNT_BITS-1:0] cap);
        echo_chan_t n;
        n = c;
        if (!c.pending)
        begin
            n.first_edge = cap;
            n.pending    = 1'b1;
        end
        else
        begin
            if (cap > c.first_edge)
                n.width = cap - c.first_edge;
            else if (c.first_edge > cap)
                n.width = {COUNT_BITS{1'b1}} - c.first_edge + cap;
            n.previous = c.newest;
            n.newest   = n.width;
            n.pending  = 1'b0;
        end
        return n;
    endfunction

    function automatic sec_pkg::sec_flags_t gesture_flags(echo_chan_t xc, echo_chan_t yc,
                                                          logic y_done,
                                                          sec_pkg::sec_cfg_t t);
        sec_pkg::sec_flags_t   f;
        logic                  x_in;
        logic                  y_in;
        logic                  y_live;
        logic [COUNT_BITS-1:0] d;
        f      = '0;
        x_in   = (xc.newest < t.x_range) && (xc.previous < t.x_range);
        y_in   = (yc.newest < t.y_range) && (yc.previous < t.y_range);
        y_live = y_done && (yc.width != '0);
        if (xc.newest < xc.previous && x_in)
        begin
            d            = xc.previous - xc.newest;
            f.right_slow = (d > t.swipe_min) && (d < t.swipe_fast);
            f.right_fast = (d >= t.swipe_fast) && (d < t.swipe_max);
        end
        if (xc.newest > xc.previous && x_in)
        begin
            d           = xc.newest - xc.previous;
            f.left_slow = (d > t.swipe_min) && (d < t.swipe_fast);
            f.left_fast = (d >= t.swipe_fast) && (d < t.swipe_max);
        end
        if (yc.newest < yc.previous && y_in && y_live)
        begin
            d      = yc.previous - yc.newest;
            f.drop = (d > t.drop_min) && (d < t.drop_max);
        end
        if (yc.newest > yc.previous && y_live && yc.previous != '0)
        begin
            d        = yc.newest - yc.previous;
            f.rotate = d > t.rotate_min;
        end
        return f;
    endfunction

    task automatic check_flag(string name, logic want, logic got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        sec_pkg::sec_flags_t want;
        sec_pkg::sec_flags_t got;
        if (!rst_n)
        begin
            x_chan                = '0;
            y_chan                = '0;
            y_seen                = 1'b0;
            thresholds.swipe_min  = sec_pkg::SWIPE_MIN_RST;
            thresholds.swipe_fast = sec_pkg::SWIPE_FAST_RST;
            thresholds.swipe_max  = sec_pkg::SWIPE_MAX_RST;
            thresholds.x_range    = sec_pkg::X_RANGE_RST;
            thresholds.drop_min   = sec_pkg::DROP_MIN_RST;
            thresholds.drop_max   = sec_pkg::DROP_MAX_RST;
            thresholds.y_range    = sec_pkg::Y_RANGE_RST;
            thresholds.rotate_min = sec_pkg::ROTATE_MIN_RST;
            flags_due.delete();
        end
        else
        begin
            // drain the output side first: a word leaving now belongs to an
            // earlier capture than one entering at the same edge
            if (m_tvalid && m_tready)
            begin
                if (flags_due.size() == 0)
                begin
                    $error("flag word %h with no capture waiting", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = flags_due.pop_front();
                    got  = sec_pkg::sec_flags_t'(m_tdata[sec_pkg::FLAG_BITS-1:0]);
                    check_flag("right_slow", want.right_slow, got.right_slow);
                    check_flag("right_fast", want.right_fast, got.right_fast);
                    check_flag("left_slow", want.left_slow, got.left_slow);
                    check_flag("left_fast", want.left_fast, got.left_fast);
                    check_flag("drop", want.drop, got.drop);
                    check_flag("rotate", want.rotate, got.rotate);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == sec_pkg::AXIS_Y)
                begin
                    if (y_chan.pending)
                        y_seen = 1'b1;
                    y_chan = echo_edge(y_chan, s_tdata[COUNT_BITS-1:0]);
                end
                else
                    x_chan = echo_edge(x_chan, s_tdata[COUNT_BITS-1:0]);
                flags_due.push_back(gesture_flags(x_chan, y_chan, y_seen, thresholds));
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    sec_pkg::REG_SWIPE_MIN:  thresholds.swipe_min  = cfg_data;
                    sec_pkg::REG_SWIPE_FAST: thresholds.swipe_fast = cfg_data;
                    sec_pkg::REG_SWIPE_MAX:  thresholds.swipe_max  = cfg_data;
                    sec_pkg::REG_X_RANGE:    thresholds.x_range    = cfg_data;
                    sec_pkg::REG_DROP_MIN:   thresholds.drop_min   = cfg_data;
                    sec_pkg::REG_DROP_MAX:   thresholds.drop_max   = cfg_data;
                    sec_pkg::REG_Y_RANGE:    thresholds.y_range    = cfg_data;
                    sec_pkg::REG_ROTATE_MIN: thresholds.rotate_min = cfg_data;
                    default: ;
                endcase
            end
        end
        pending_results = flags_due.size();
    end

endmodule

// ===== dv/sonar_echo_swipe_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_echo_swipe_classifier_tb
// Drives echo capture words into the swipe classifier: a short directed
// opening, then phases of random capture pairs under different threshold
// settings and idle/stall patterns. The flag checker gives the verdict data.
// ----------------------------------------------------------------------------
module sonar_echo_swipe_classifier_tb;

    localparam int CW           = sec_pkg::COUNT_BITS_DEF;
    localparam int DW           = ((CW + 7) / 8) * 8;
    localparam int FLUSH_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int GESTURES     = 65;
    localparam int OPENING      = 24;

    typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH } idle_mode_t;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic [DW-1:0]                     s_tdata  = '0;
    logic                              s_tuser  = 1'b0;
    logic                              m_tready = 1'b0;
    logic                              cfg_we   = 1'b0;
    logic [sec_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [sec_pkg::CFG_BITS-1:0]      cfg_data = '0;
    logic                              s_tready;
    logic                              m_tvalid;
    logic [sec_pkg::OUT_DATA_BITS-1:0] m_tdata;

    int mismatches;
    int pending_results;
    int cycles         = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    logic [sec_pkg::CFG_BITS-1:0] cfg_now [8];
    logic [CW-1:0]                last_width [2];
    logic                         held [2];       // axis holds a first edge
    logic [CW:0]                  opening_words [OPENING];

    sonar_echo_swipe_classifier #(.COUNT_BITS(CW)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    swipe_flag_checker #(.COUNT_BITS(CW)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sonar_echo_swipe_classifier verification failed");
            $finish;
        end
    end

    task automatic send_word(logic ax, logic [CW-1:0] cap);
        if (src_gap_pct != 0)
        begin
            while ($urandom_range(0, 99) < src_gap_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ax;
        s_tdata  <= DW'(cap);
        held[ax] = ~held[ax];
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold off until every flag word is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic load_thresholds(sec_pkg::sec_cfg_t t);
        logic [sec_pkg::CFG_BITS-1:0] vals [8];
        vals[sec_pkg::REG_SWIPE_MIN]  = t.swipe_min;
        vals[sec_pkg::REG_SWIPE_FAST] = t.swipe_fast;
        vals[sec_pkg::REG_SWIPE_MAX]  = t.swipe_max;
        vals[sec_pkg::REG_X_RANGE]    = t.x_range;
        vals[sec_pkg::REG_DROP_MIN]   = t.drop_min;
        vals[sec_pkg::REG_DROP_MAX]   = t.drop_max;
        vals[sec_pkg::REG_Y_RANGE]    = t.y_range;
        vals[sec_pkg::REG_ROTATE_MIN] = t.rotate_min;
        for (int r = 0; r < 8; r++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= sec_pkg::CFG_ADDR_BITS'(r);
            cfg_data <= vals[r];
            cfg_now[r] = vals[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly clean pairs whose width moves from the last one by about a threshold or a random step,
    // some with a fully random width; the rest is stray single edges that shift the pairing
    task automatic random_gesture();
        logic          ax;
        int            pick;
        int            w;
        logic [CW-1:0] first;
        ax   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 10 || held[ax])
        begin
            send_word(ax, CW'($urandom_range(0, 2**CW - 1)));
            return;
        end
        if (pick < 50)
            w = int'(cfg_now[$urandom_range(0, 7)]) + $urandom_range(0, 2) - 1;
        else if (pick < 90)
            w = $urandom_range(0, 7000);
        else
            w = $urandom_range(0, 2**CW - 1);
        if (pick < 90)
            w = $urandom_range(0, 1) ? int'(last_width[ax]) + w : int'(last_width[ax]) - w;
        if (w < 0)
            w = -w;
        w = w % (2**CW);
        if ($urandom_range(0, 3) != 0)
            first = CW'($urandom_range(0, 2**CW - 1 - w));
        else
            first = CW'($urandom_range(0, 2**CW - 1));
        last_width[ax] = CW'(w);
        send_word(ax, first);
        send_word(ax, first + CW'(w));
    endtask

    initial
    begin
        sec_pkg::sec_cfg_t t;
        idle_mode_t        mode;
        held[0]       = 1'b0;
        held[1]       = 1'b0;
        last_width[0] = '0;
        last_width[1] = '0;
        cfg_now[sec_pkg::REG_SWIPE_MIN]  = sec_pkg::SWIPE_MIN_RST;
        cfg_now[sec_pkg::REG_SWIPE_FAST] = sec_pkg::SWIPE_FAST_RST;
        cfg_now[sec_pkg::REG_SWIPE_MAX]  = sec_pkg::SWIPE_MAX_RST;
        cfg_now[sec_pkg::REG_X_RANGE]    = sec_pkg::X_RANGE_RST;
        cfg_now[sec_pkg::REG_DROP_MIN]   = sec_pkg::DROP_MIN_RST;
        cfg_now[sec_pkg::REG_DROP_MAX]   = sec_pkg::DROP_MAX_RST;
        cfg_now[sec_pkg::REG_Y_RANGE]    = sec_pkg::Y_RANGE_RST;
        cfg_now[sec_pkg::REG_ROTATE_MIN] = sec_pkg::ROTATE_MIN_RST;
        // default thresholds: left fast, right fast on a wrap to zero, left
        // slow, equal captures, right slow on a small wrap, width out of range;
        // then Y: rise from zero, drop, rotate, equal, zero width, rise from zero
        opening_words = '{
            {sec_pkg::AXIS_X, 16'h0000}, {sec_pkg::AXIS_X, 16'd1000},
            {sec_pkg::AXIS_X, 16'hFFFF}, {sec_pkg::AXIS_X, 16'h0000},
            {sec_pkg::AXIS_X, 16'd100},  {sec_pkg::AXIS_X, 16'd300},
            {sec_pkg::AXIS_X, 16'd500},  {sec_pkg::AXIS_X, 16'd500},
            {sec_pkg::AXIS_X, 16'hFFF0}, {sec_pkg::AXIS_X, 16'h0000},
            {sec_pkg::AXIS_X, 16'h0000}, {sec_pkg::AXIS_X, 16'hFFFF},
            {sec_pkg::AXIS_Y, 16'h1234}, {sec_pkg::AXIS_Y, 16'h21D4},
            {sec_pkg::AXIS_Y, 16'h8000}, {sec_pkg::AXIS_Y, 16'h85DC},
            {sec_pkg::AXIS_Y, 16'h0100}, {sec_pkg::AXIS_Y, 16'h1488},
            {sec_pkg::AXIS_Y, 16'h4000}, {sec_pkg::AXIS_Y, 16'h4000},
            {sec_pkg::AXIS_Y, 16'hFFFF}, {sec_pkg::AXIS_Y, 16'h0000},
            {sec_pkg::AXIS_Y, 16'h2000}, {sec_pkg::AXIS_Y, 16'h3770}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < OPENING; i++)
            send_word(opening_words[i][CW], opening_words[i][CW-1:0]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: ;  // reset thresholds
                1: load_thresholds('0);
                2: load_thresholds('1);
                6:
                begin
                    t = sec_pkg::sec_cfg_t'({$urandom, $urandom, $urandom, $urandom});
                    load_thresholds(t);
                end
                7:
                begin
                    t.swipe_min  = sec_pkg::SWIPE_MIN_RST;
                    t.swipe_fast = sec_pkg::SWIPE_FAST_RST;
                    t.swipe_max  = sec_pkg::SWIPE_MAX_RST;
                    t.x_range    = sec_pkg::X_RANGE_RST;
                    t.drop_min   = sec_pkg::DROP_MIN_RST;
                    t.drop_max   = sec_pkg::DROP_MAX_RST;
                    t.y_range    = sec_pkg::Y_RANGE_RST;
                    t.rotate_min = sec_pkg::ROTATE_MIN_RST;
                    load_thresholds(t);
                end
                default:
                begin
                    t.swipe_min  = sec_pkg::CFG_BITS'($urandom_range(0, 400));
                    t.swipe_fast = sec_pkg::CFG_BITS'($urandom_range(400, 2000));
                    t.swipe_max  = sec_pkg::CFG_BITS'($urandom_range(2000, 8000));
                    t.x_range    = sec_pkg::CFG_BITS'($urandom_range(2000, 20000));
                    t.drop_min   = sec_pkg::CFG_BITS'($urandom_range(0, 800));
                    t.drop_max   = sec_pkg::CFG_BITS'($urandom_range(800, 6000));
                    t.y_range    = sec_pkg::CFG_BITS'($urandom_range(2000, 20000));
                    t.rotate_min = sec_pkg::CFG_BITS'($urandom_range(0, 6000));
                    load_thresholds(t);
                end
            endcase

            mode           = idle_mode_t'(p % 4);
            src_gap_pct    = (mode == IDLE_SRC) ? 50 : (mode == IDLE_BOTH) ? 23 : 0;
            sink_stall_pct = (mode == IDLE_SINK) ? 50 : (mode == IDLE_BOTH) ? 23 : 0;

            for (int g = 0; g < GESTURES; g++)
            begin
                if (g == GESTURES / 2)
                    drain();
                random_gesture();
            end
            drain();
        end

        if (mismatches == 0 && pending_results == 0)
            $display("sonar_echo_swipe_classifier verification clean");
        else
            $display("sonar_echo_swipe_classifier verification failed");
        $finish;
    end

endmodule
